/* rtl/shop_pkg.sv */
`default_nettype none

package shop_pkg;

  // message and varint limits
  localparam int unsigned MAX_MESSAGE_BYTES = 65536;
  localparam int unsigned MAX_VARINT_BYTES  = 10;
  localparam int unsigned MIN_MESSAGE_BYTES = 5;

  // field widths
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned SEEN_W    = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ERR_W     = 2;

  // depth of the result queue
  localparam int unsigned RESULT_DEPTH = 4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_OFFSET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_SHORT  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_ID  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_VARINT = 2'd2;

  // header magic byte
  localparam logic [7:0] MAGIC_BYTE = 8'h00;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             start_of_message;
    logic [LEN_W-1:0] message_length;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic signed [63:0] offset_value;
    logic signed [31:0] id_value;
    logic [LEN_W-1:0]   payload_start;
    logic [ERR_W-1:0]   error_code;
    logic               end_of_message;
  } result_t;

  // up to two results pushed by one parsed byte, in order
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

/* rtl/shop_parser.sv */
`default_nettype none

module shop_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire shop_pkg::in_item_t in_item_i,
  input  wire logic               offsets_mode_i,
  input  wire logic               space_i,
  output shop_pkg::push_t         push_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_COUNT,
    PH_OFFS,
    PH_SKIP
  } phase_e;

  localparam int unsigned LW = shop_pkg::LEN_W;
  localparam int unsigned SW = shop_pkg::SEEN_W;

  // input register
  logic               in_valid_q;
  shop_pkg::in_item_t in_item_q;
  logic               consume;

  // parse state
  phase_e          phase_q, phase_d;
  logic [LW-1:0]   rem_q, rem_d;
  logic [LW-1:0]   pos_q, pos_d;
  logic [31:0]     id_q, id_d;
  logic [63:0]     acc_q, acc_d;
  logic [SW-1:0]   seen_q, seen_d;
  logic [LW-1:0]   offs_q, offs_d;

  // per-byte helpers
  logic [LW-1:0]   len_c;
  logic [LW-1:0]   rem_start;
  logic [LW-1:0]   rem_n;
  logic [LW-1:0]   pos_n;
  logic [31:0]     id_n;
  logic [63:0]     acc_lane;
  logic [63:0]     acc_n;
  logic [SW-1:0]   seen_n;
  logic [63:0]     zz;
  logic            count_bad;
  logic [7:0]      b;

  function automatic shop_pkg::result_t mk_error(logic [shop_pkg::ERR_W-1:0] code);
    shop_pkg::result_t r;
    r                = '0;
    r.result_kind    = shop_pkg::KIND_ERROR;
    r.error_code     = code;
    r.end_of_message = 1'b1;
    return r;
  endfunction

  function automatic shop_pkg::result_t mk_done(logic [31:0] id, logic [LW-1:0] pos);
    shop_pkg::result_t r;
    r                = '0;
    r.result_kind    = shop_pkg::KIND_DONE;
    r.id_value       = id;
    r.payload_start  = pos;
    r.end_of_message = 1'b1;
    return r;
  endfunction

  function automatic shop_pkg::result_t mk_offset(logic [63:0] v);
    shop_pkg::result_t r;
    r              = '0;
    r.result_kind  = shop_pkg::KIND_OFFSET;
    r.offset_value = v;
    return r;
  endfunction

  // input stage handshake
  assign consume    = in_valid_q && space_i;
  assign in_ready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // byte level arithmetic
  assign b         = in_item_q.data_byte;
  assign len_c     = (in_item_q.message_length > LW'(shop_pkg::MAX_MESSAGE_BYTES)) ?
                     LW'(shop_pkg::MAX_MESSAGE_BYTES) : in_item_q.message_length;
  assign rem_start = (len_c == '0) ? '0 : len_c - 1'b1;
  assign rem_n     = rem_q - 1'b1;
  assign pos_n     = pos_q + 1'b1;
  assign id_n      = {id_q[23:0], b};
  assign seen_n    = seen_q + 1'b1;

  // place the seven payload bits into the lane picked by the byte count
  always_comb begin
    acc_lane = '0;
    for (int k = 0; k < int'(shop_pkg::MAX_VARINT_BYTES); k++) begin
      if (seen_q == SW'(k)) begin
        acc_lane = 64'(b[6:0]) << (7 * k);
      end
    end
  end

  assign acc_n     = acc_q | acc_lane;
  assign zz        = {1'b0, acc_n[63:1]} ^ {64{acc_n[0]}};
  assign count_bad = zz[63] || (zz[63:LW] != '0) || (zz[LW-1:0] > rem_n);

  // next state and results of the byte in the input register
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    id_d    = id_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    offs_d  = offs_q;
    push_o  = '0;

    if (consume) begin
      if (in_item_q.start_of_message) begin
        rem_d  = rem_start;
        pos_d  = LW'(1);
        id_d   = '0;
        acc_d  = '0;
        seen_d = '0;
        offs_d = '0;
        if (len_c < LW'(shop_pkg::MIN_MESSAGE_BYTES)) begin
          push_o.n  = 2'd1;
          push_o.r0 = mk_error(shop_pkg::ERR_SHORT);
          phase_d   = PH_SKIP;
        end else if (b != shop_pkg::MAGIC_BYTE) begin
          push_o.n  = 2'd1;
          push_o.r0 = mk_error(shop_pkg::ERR_NO_ID);
          phase_d   = PH_SKIP;
        end else begin
          phase_d = PH_ID;
        end
        if (rem_start == '0) begin
          phase_d = PH_IDLE;
        end
      end else if (phase_q == PH_IDLE || rem_q == '0) begin
        phase_d = PH_IDLE;
      end else begin
        pos_d = pos_n;
        rem_d = rem_n;
        unique case (phase_q) inside
          PH_ID: begin
            id_d = id_n;
            if (pos_n == LW'(shop_pkg::MIN_MESSAGE_BYTES)) begin
              if (!offsets_mode_i) begin
                push_o.n  = 2'd1;
                push_o.r0 = mk_done(id_n, pos_n);
                phase_d   = PH_SKIP;
              end else begin
                phase_d = PH_COUNT;
                acc_d   = '0;
                seen_d  = '0;
                if (rem_n == '0) begin
                  push_o.n  = 2'd1;
                  push_o.r0 = mk_error(shop_pkg::ERR_SHORT);
                  phase_d   = PH_SKIP;
                end
              end
            end
          end
          PH_COUNT, PH_OFFS: begin
            acc_d  = acc_n;
            seen_d = seen_n;
            if (b[7]) begin
              // varint continues
              if (seen_n >= SW'(shop_pkg::MAX_VARINT_BYTES)) begin
                push_o.n  = 2'd1;
                push_o.r0 = mk_error(shop_pkg::ERR_VARINT);
                phase_d   = PH_SKIP;
              end else if (rem_n == '0) begin
                push_o.n  = 2'd1;
                push_o.r0 = mk_error(shop_pkg::ERR_SHORT);
                phase_d   = PH_SKIP;
              end
            end else begin
              // varint complete
              acc_d  = '0;
              seen_d = '0;
              if (phase_q == PH_COUNT) begin
                if (count_bad) begin
                  push_o.n  = 2'd1;
                  push_o.r0 = mk_error(shop_pkg::ERR_SHORT);
                  phase_d   = PH_SKIP;
                end else if (zz == '0) begin
                  push_o.n  = 2'd2;
                  push_o.r0 = mk_offset('0);
                  push_o.r1 = mk_done(id_q, pos_n);
                  phase_d   = PH_SKIP;
                end else begin
                  offs_d  = zz[LW-1:0];
                  phase_d = PH_OFFS;
                end
              end else begin
                push_o.n  = 2'd1;
                push_o.r0 = mk_offset(zz);
                offs_d    = offs_q - 1'b1;
                if (offs_q == LW'(1)) begin
                  push_o.n  = 2'd2;
                  push_o.r1 = mk_done(id_q, pos_n);
                  phase_d   = PH_SKIP;
                end else if (rem_n == '0) begin
                  push_o.n  = 2'd2;
                  push_o.r1 = mk_error(shop_pkg::ERR_SHORT);
                  phase_d   = PH_SKIP;
                end
              end
            end
          end
          default: begin
          end
        endcase
        if (rem_n == '0) begin
          phase_d = PH_IDLE;
        end
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rem_q   <= '0;
      pos_q   <= '0;
      id_q    <= '0;
      acc_q   <= '0;
      seen_q  <= '0;
      offs_q  <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      id_q    <= id_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      offs_q  <= offs_d;
    end
  end

  // results only come from a byte taken out of the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n != 2'd0) |-> consume)
    else $error("results pushed without a parsed byte");

  // a pair of results is always an offset followed by the final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n == 2'd2) |->
      (push_o.r0.result_kind == shop_pkg::KIND_OFFSET) && push_o.r1.end_of_message)
    else $error("bad result pair");

  // an exhausted message always falls back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (rem_q != '0))
    else $error("active phase with no bytes left");

endmodule

`default_nettype wire

/* rtl/shop_result_fifo.sv */
`default_nettype none

module shop_result_fifo #(
  parameter int unsigned Depth = shop_pkg::RESULT_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire shop_pkg::push_t   push_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output shop_pkg::result_t      out_result_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  shop_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [PtrW-1:0]   wr_next;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // room for a full pair of results
  assign space_o      = (count_q <= CntW'(Depth - 2));
  assign out_valid_o  = (count_q != '0);
  assign out_result_o = mem_q[rd_q];
  assign pop          = out_valid_o && out_ready_i;
  assign wr_next      = next_ptr(wr_q);

  // pointer and fill count update
  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q + CntW'(push_i.n) - CntW'(pop);
    if (push_i.n == 2'd1) begin
      wr_d = wr_next;
    end else if (push_i.n == 2'd2) begin
      wr_d = next_ptr(wr_next);
    end
    if (pop) begin
      rd_d = next_ptr(rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue fill count out of range");

  // the parser only pushes when a full pair fits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (count_q <= CntW'(Depth - 2)))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_i.n == 2'd0)) |=> (count_q == $past(count_q) - 1'b1))
    else $error("result transfer did not drain the queue");

endmodule

`default_nettype wire

/* rtl/schema_header_offset_parser.sv */
// a byte is parsed out of the input register; its results are then offered from the result queue
// throughput: one byte per cycle while the queue has room for two results, which are read singly
// the pace is set by the single result read port of the four-entry result queue
// reset: parser idle, offsets_mode set to 1, input register and result queue empty
`default_nettype none

module schema_header_offset_parser #(
  parameter int unsigned ResultDepth = shop_pkg::RESULT_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire shop_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output shop_pkg::result_t       out_result_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_i
);

  logic            offsets_mode_q;
  logic            space;
  shop_pkg::push_t push;

  // configuration register, one write per transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      offsets_mode_q <= cfg_data_i;
    end
  end

  // byte parser with input register
  shop_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .offsets_mode_i (offsets_mode_q),
    .space_i        (space),
    .push_o         (push)
  );

  // result queue
  shop_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_o      (space),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (out_result_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_schema_header_offset_parser.sv */
module tb_schema_header_offset_parser;

  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned DRAIN_LIMIT    = 5000;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned NUM_PHASES     = 5;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned LEN_W          = shop_pkg::LEN_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCHEMA_ID, ST_COUNT, ST_OFFSETS, ST_SKIP
  } parse_state_e;

  // predicts header parse results and holds them until they come out
  class header_parse_board;
    logic              offsets_mode = 1'b1;
    parse_state_e      state        = ST_IDLE;
    logic [LEN_W-1:0]  remain_count = '0;
    logic [LEN_W-1:0]  position     = '0;
    logic [LEN_W-1:0]  offsets_left = '0;
    logic [31:0]       id_accum     = '0;
    logic [63:0]       varint_accum = '0;
    logic [shop_pkg::SEEN_W-1:0] varint_seen = '0;
    shop_pkg::result_t expected_results[$];
    int unsigned       fail_count   = 0;

    function void set_mode(logic mode);
      offsets_mode = mode;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // done and error end the message, the rest of it is skipped
    function void push_result(logic [shop_pkg::KIND_W-1:0] kind, logic [63:0] off,
                              logic [shop_pkg::ERR_W-1:0] err);
      shop_pkg::result_t r;
      r = '0;
      r.result_kind = kind;
      r.offset_value = off;
      r.error_code = err;
      r.end_of_message = (kind != shop_pkg::KIND_OFFSET);
      if (kind == shop_pkg::KIND_DONE) begin
        r.id_value = id_accum;
        r.payload_start = position;
      end
      expected_results.insert(expected_results.size(), r);
      if (kind != shop_pkg::KIND_OFFSET) state = ST_SKIP;
    endfunction

    // one accepted byte through the parser
    function void note_input(shop_pkg::in_item_t it);
      logic [LEN_W-1:0] len;
      logic [63:0]      value;
      if (it.start_of_message) begin
        len = (it.message_length > shop_pkg::MAX_MESSAGE_BYTES) ?
              LEN_W'(shop_pkg::MAX_MESSAGE_BYTES) : it.message_length;
        remain_count = (len != 0) ? len - 1'b1 : '0;
        position = LEN_W'(1);
        id_accum = '0;
        varint_accum = '0;
        varint_seen = '0;
        offsets_left = '0;
        if (len < shop_pkg::MIN_MESSAGE_BYTES)
          push_result(shop_pkg::KIND_ERROR, '0, shop_pkg::ERR_SHORT);
        else if (it.data_byte != shop_pkg::MAGIC_BYTE)
          push_result(shop_pkg::KIND_ERROR, '0, shop_pkg::ERR_NO_ID);
        else state = ST_SCHEMA_ID;
        if (remain_count == 0) state = ST_IDLE;
      end else if (state == ST_IDLE || remain_count == 0) begin
        state = ST_IDLE;
      end else begin
        position++;
        remain_count--;
        case (state)
          ST_SCHEMA_ID: begin
            id_accum = {id_accum[23:0], it.data_byte};
            if (position == shop_pkg::MIN_MESSAGE_BYTES) begin
              if (!offsets_mode) begin
                push_result(shop_pkg::KIND_DONE, '0, '0);
              end else begin
                state = ST_COUNT;
                varint_accum = '0;
                varint_seen = '0;
                if (remain_count == 0)
                  push_result(shop_pkg::KIND_ERROR, '0, shop_pkg::ERR_SHORT);
              end
            end
          end
          ST_COUNT, ST_OFFSETS: begin
            // bits past bit 63 fall off the shift
            varint_accum = varint_accum |
                           ({57'd0, it.data_byte[6:0]} << (7 * varint_seen));
            varint_seen++;
            if (it.data_byte[7]) begin
              if (varint_seen >= shop_pkg::MAX_VARINT_BYTES)
                push_result(shop_pkg::KIND_ERROR, '0, shop_pkg::ERR_VARINT);
              else if (remain_count == 0)
                push_result(shop_pkg::KIND_ERROR, '0, shop_pkg::ERR_SHORT);
            end else begin
              value = (varint_accum >> 1) ^ {64{varint_accum[0]}};
              varint_accum = '0;
              varint_seen = '0;
              if (state == ST_COUNT) begin
                if (value[63] || value > remain_count) begin
                  push_result(shop_pkg::KIND_ERROR, '0, shop_pkg::ERR_SHORT);
                end else if (value == 0) begin
                  push_result(shop_pkg::KIND_OFFSET, '0, '0);
                  push_result(shop_pkg::KIND_DONE, '0, '0);
                end else begin
                  offsets_left = value[LEN_W-1:0];
                  state = ST_OFFSETS;
                end
              end else begin
                push_result(shop_pkg::KIND_OFFSET, value, '0);
                offsets_left--;
                if (offsets_left == 0)
                  push_result(shop_pkg::KIND_DONE, '0, '0);
                else if (remain_count == 0)
                  push_result(shop_pkg::KIND_ERROR, '0, shop_pkg::ERR_SHORT);
              end
            end
          end
          default: ;
        endcase
        if (remain_count == 0) state = ST_IDLE;
      end
    endfunction

    function void note_failure(string what, shop_pkg::result_t want,
                               shop_pkg::result_t got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%s: expected kind %0d off %0d id %0d pos %0d err %0d eom %0d",
                 what, want.result_kind, want.offset_value, want.id_value,
                 want.payload_start, want.error_code, want.end_of_message);
        $display("  actual kind %0d off %0d id %0d pos %0d err %0d eom %0d",
                 got.result_kind, got.offset_value, got.id_value,
                 got.payload_start, got.error_code, got.end_of_message);
      end
    endfunction

    function void check_result(shop_pkg::result_t got);
      shop_pkg::result_t want;
      if (expected_results.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind ||
            got.offset_value !== want.offset_value ||
            got.id_value !== want.id_value ||
            got.payload_start !== want.payload_start ||
            got.error_code !== want.error_code ||
            got.end_of_message !== want.end_of_message)
          note_failure("result mismatch", want, got);
      end
    endfunction

    // results that never came count one failure each
    function void end_check();
      if (expected_results.size() != 0) begin
        note_failure("missing result", expected_results[0], '0);
        fail_count += expected_results.size() - 1;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  shop_pkg::in_item_t in_item   = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  shop_pkg::result_t  out_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_data  = 1'b0;
  logic               cfg_ready;

  // stimulus control shared with the receiver
  logic idle_en  = 1'b1;
  logic hold_req = 1'b0;

  logic [7:0]       msg_bytes[$];
  logic [LEN_W-1:0] msg_len;
  int unsigned      msg_count;

  header_parse_board sb;

  schema_header_offset_parser u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_item_i    (in_item),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_result_o (out_result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  // clock
  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("tb_schema_header_offset_parser NOT OK");
    $finish;
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_mode(cfg_data);
      if (in_valid && in_ready) sb.note_input(in_item);
      if (out_valid && out_ready) sb.check_result(out_result);
    end
  end

  // receiver with random stalls and one long hold on request
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] zigzag(input logic [63:0] v);
    return {v[62:0], 1'b0} ^ {64{v[63]}};
  endfunction

  function automatic void add_byte(input logic [7:0] value);
    msg_bytes.insert(msg_bytes.size(), value);
  endfunction

  // pad adds redundant continuation bytes, which may run past the varint limit
  function automatic void put_varint(input logic [63:0] u, input int unsigned pad);
    logic [63:0] rest;
    rest = u;
    while (rest[63:7] != 0) begin
      add_byte({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    if (pad == 0) begin
      add_byte({1'b0, rest[6:0]});
    end else begin
      add_byte({1'b1, rest[6:0]});
      repeat (pad - 1) add_byte(8'h80);
      add_byte(8'h00);
    end
  endfunction

  function automatic logic [63:0] rand_offset();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0:       v = 64'h8000_0000_0000_0000;
      1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
      2:       v = {$urandom, $urandom};
      default: v = {$urandom, $urandom} >> $urandom_range(40, 63);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // mostly well-formed messages, some broken ones and some noise
  function automatic void build_message();
    int unsigned shape;
    int unsigned count;
    int unsigned size;
    shape = $urandom_range(0, 99);
    msg_bytes.delete();
    if (shape < 10) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      msg_len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 8));
      msg_count = msg_bytes.size();
      return;
    end
    add_byte(shop_pkg::MAGIC_BYTE);
    repeat (4) add_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
    if (shape < 18) begin
      // count negative or beyond the bytes left
      if (shape[0]) put_varint(zigzag(-64'($urandom_range(1, 1000))), 0);
      else put_varint(zigzag(64'($urandom_range(8, 300))), 0);
    end else if (shape < 26) begin
      // runaway varint in the count or in the first offset
      if (shape[0]) put_varint(zigzag(64'd1), 0);
      repeat ($urandom_range(10, 12)) add_byte({1'b1, 7'($urandom)});
    end else begin
      count = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
      put_varint(zigzag(64'(count)), ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0);
      repeat (count)
        put_varint(zigzag(rand_offset()),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0);
    end
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    size = msg_bytes.size();
    msg_count = size;
    case ($urandom_range(0, 19))
      0, 1: msg_len = LEN_W'($urandom_range(1, size - 1));
      2: begin
        // cut short, abandoned by the next start
        msg_len = LEN_W'(size);
        msg_count = $urandom_range(1, size);
      end
      3:       msg_len = '1;
      4:       msg_len = LEN_W'(size + $urandom_range(1, 20));
      default: msg_len = LEN_W'(size);
    endcase
  endfunction

  task automatic send_byte(input shop_pkg::in_item_t it);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_message();
    shop_pkg::in_item_t item;
    for (int i = 0; i < msg_count; i++) begin
      item.data_byte = msg_bytes[i];
      item.start_of_message = (i == 0);
      item.message_length = (i == 0) ? msg_len : LEN_W'($urandom);
      send_byte(item);
    end
  endtask

  task automatic send_listed(input logic [LEN_W-1:0] len);
    msg_len = len;
    msg_count = msg_bytes.size();
    send_message();
  endtask

  // stop offering and let every expected result come out
  task automatic wait_results();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // zero length, then a stray byte while idle
    msg_bytes = '{8'h00};
    send_listed('0);
    send_byte('{data_byte: 8'h3C, start_of_message: 1'b0, message_length: '1});
    // short length and bad magic together
    msg_bytes = '{8'h5A};
    send_listed(LEN_W'(4));
    // bad magic only
    msg_bytes = '{8'hFF};
    send_listed(LEN_W'(5));
    // restart in the middle of a header
    msg_bytes = '{8'h00, 8'h01};
    send_listed(LEN_W'(9));
    // length above the limit, id of all ones, one offset of -1, then payload
    msg_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h01, 8'hAA};
    send_listed('1);
    // count larger than the bytes left
    msg_bytes = '{8'h00, 8'h80, 8'h00, 8'h00, 8'h01, 8'h04};
    send_listed(LEN_W'(7));
    // count of zero gives offset zero and done from one byte
    msg_bytes = '{8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_listed(LEN_W'(6));
  endtask

  initial begin
    int unsigned phase_items;
    logic        paused;
    sb = new;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(p[0]);
      phase_items = 0;
      paused = 1'b0;
      if (p == NUM_PHASES - 1) idle_en = 1'b0;
      if (p == 1) begin
        // long receiver hold while short error messages keep coming
        hold_req = 1'b1;
        msg_bytes = '{8'h00};
        repeat (16) send_listed('0);
        phase_items = 16;
      end
      while (phase_items < PHASE_ITEMS) begin
        if (p == 2 && !paused && phase_items >= PHASE_ITEMS / 2) begin
          wait_results();
          paused = 1'b1;
        end
        build_message();
        send_message();
        phase_items += msg_count;
      end
    end
    wait_results();
    sb.end_check();
    if (sb.fail_count == 0) $display("tb_schema_header_offset_parser OK");
    else $display("tb_schema_header_offset_parser NOT OK");
    $finish;
  end

endmodule
